// ----- hw/rtl/afm_pkg.sv -----
// Package for the adaptive frequency model: sizes, command codes and the
// request and response beat types. No dependencies.
`default_nettype none

package afm_pkg;

   localparam int ALPHABET   = 257;
   localparam int COUNT_BITS = 32;
   localparam int IDX_W      = $clog2(ALPHABET);
   localparam int CMP_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   localparam logic [IDX_W-1:0]      EOS_SYM   = IDX_W'(ALPHABET - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] TOTAL_RST = COUNT_BITS'(ALPHABET);

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [8:0]  symbol_in;
      logic [31:0] target_value;
   } req_type;

   typedef struct packed {
      logic [8:0]  symbol_out;
      logic [31:0] low_bound;
      logic [31:0] high_bound;
      logic [31:0] total_count;
      logic        range_error;
      logic        overflow;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/afm_count_ram.sv -----
// Simple dual-port RAM holding the per-symbol counts.
// One write port, one read port with registered read data. No dependencies.
`default_nettype none

module afm_count_ram #(
   parameter int DEPTH  = 257,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/adaptive_frequency_model_core.sv -----
// Top level of the adaptive order-0 frequency model: sequencer that walks
// the count RAM. Depends on afm_pkg and afm_count_ram.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      beat taken when start & !busy
//   response  rsp_strobe, rsp_item       one-cycle strobe, no backpressure
//
// An item walks entries 0 to k, k being the symbol index (encode) or the index
// of the decoded symbol: the count RAM is read one entry per cycle while the
// cumulative low bound builds up. A decode whose target is not below the
// total answers at once from idle, with the strobe in the next cycle.
// After reset and after every end-of-stream item the RAM is refilled with
// ones, one entry per cycle; busy stays high meanwhile.
// The response strobe is registered: it rises in the cycle after the last walk cycle.
`default_nettype none

module adaptive_frequency_model_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire afm_pkg::req_type req_item,
   output logic                 rsp_strobe,
   output afm_pkg::rsp_type     rsp_item
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type                            state_ff;
   logic [afm_pkg::IDX_W-1:0]            clr_ff;
   logic [afm_pkg::IDX_W-1:0]            idx_ff;
   logic [afm_pkg::IDX_W-1:0]            sym_ff;
   logic                                 cmd_ff;
   logic [31:0]                          target_ff;
   logic [afm_pkg::COUNT_BITS-1:0]       low_ff;
   logic [afm_pkg::COUNT_BITS-1:0]       total_ff;
   logic                                 rsp_strobe_ff;
   afm_pkg::rsp_type                     rsp_ff;

   logic                                 wr_en;
   logic [afm_pkg::IDX_W-1:0]            wr_addr;
   logic [afm_pkg::COUNT_BITS-1:0]       wr_data;
   logic [afm_pkg::IDX_W-1:0]            rd_addr;
   logic [afm_pkg::COUNT_BITS-1:0]       rd_data;

   logic [afm_pkg::COUNT_BITS-1:0]       next_low;
   logic [afm_pkg::COUNT_BITS-1:0]       high_in;
   logic                                 dec_hit;
   logic                                 enc_hit;
   logic                                 done;
   logic                                 tail_miss;
   logic                                 upd_ok;
   logic                                 accept;
   logic                                 target_bad;
   logic [afm_pkg::IDX_W-1:0]            sym_in;

   assign accept     = start && (state_ff == ST_IDLE);
   assign target_bad = afm_pkg::CMP_W'(req_item.target_value) >= afm_pkg::CMP_W'(total_ff);
   assign sym_in     = (32'(req_item.symbol_in) >= 32'(afm_pkg::ALPHABET)) ?
                       afm_pkg::EOS_SYM : afm_pkg::IDX_W'(req_item.symbol_in);

   assign next_low  = low_ff + rd_data;
   assign high_in   = low_ff + rd_data;
   assign enc_hit   = (cmd_ff == afm_pkg::CMD_ENCODE) && (idx_ff == sym_ff);
   assign dec_hit   = (cmd_ff == afm_pkg::CMD_DECODE) &&
                      (afm_pkg::CMP_W'(target_ff) < afm_pkg::CMP_W'(next_low));
   assign done      = (state_ff == ST_WALK) && (enc_hit || dec_hit);
   // decode ran past the last entry: finish as an end-of-stream encode
   assign tail_miss = (state_ff == ST_WALK) && (cmd_ff == afm_pkg::CMD_DECODE) &&
                      !dec_hit && (idx_ff == afm_pkg::EOS_SYM);
   assign upd_ok    = (idx_ff != afm_pkg::EOS_SYM) && (total_ff != afm_pkg::COUNT_MAX);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data + afm_pkg::COUNT_ONE;
      rd_addr = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = afm_pkg::COUNT_ONE;
         end
         ST_WALK: begin
            wr_en   = done && upd_ok;
            rd_addr = tail_miss ? idx_ff : afm_pkg::IDX_W'(idx_ff + 1'b1);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   afm_count_ram #(
      .DEPTH  (afm_pkg::ALPHABET),
      .WIDTH  (afm_pkg::COUNT_BITS),
      .ADDR_W (afm_pkg::IDX_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               rsp_strobe_ff <= 1'b0;
               clr_ff <= (clr_ff == afm_pkg::EOS_SYM) ? '0 :
                         afm_pkg::IDX_W'(clr_ff + 1'b1);
               if (clr_ff == afm_pkg::EOS_SYM) begin
                  total_ff <= afm_pkg::TOTAL_RST;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_strobe_ff <= accept && (req_item.cmd == afm_pkg::CMD_DECODE) &&
                                target_bad;
               if (accept) begin
                  cmd_ff    <= req_item.cmd;
                  sym_ff    <= sym_in;
                  target_ff <= req_item.target_value;
                  low_ff    <= '0;
                  idx_ff    <= '0;
                  if (req_item.cmd == afm_pkg::CMD_DECODE && target_bad) begin
                     // answer at once, state untouched
                     rsp_ff.symbol_out    <= '0;
                     rsp_ff.low_bound     <= '0;
                     rsp_ff.high_bound    <= '0;
                     rsp_ff.total_count   <= 32'(total_ff);
                     rsp_ff.range_error   <= 1'b1;
                     rsp_ff.overflow      <= 1'b0;
                  end else begin
                     state_ff <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               rsp_strobe_ff <= done;
               if (done) begin
                  rsp_ff.symbol_out    <= 9'(32'(idx_ff));
                  rsp_ff.low_bound     <= 32'(low_ff);
                  rsp_ff.high_bound    <= 32'(high_in);
                  rsp_ff.total_count   <= 32'(total_ff);
                  rsp_ff.range_error   <= 1'b0;
                  rsp_ff.overflow      <= (idx_ff != afm_pkg::EOS_SYM) &&
                                          (total_ff == afm_pkg::COUNT_MAX);
                  if (upd_ok) begin
                     total_ff <= total_ff + afm_pkg::COUNT_ONE;
                  end
                  state_ff <= (idx_ff == afm_pkg::EOS_SYM) ? ST_CLEAR : ST_IDLE;
               end else if (tail_miss) begin
                  // hold the index and re-read the last entry
                  low_ff <= next_low;
                  cmd_ff <= afm_pkg::CMD_ENCODE;
                  sym_ff <= afm_pkg::EOS_SYM;
               end else begin
                  low_ff <= next_low;
                  idx_ff <= afm_pkg::IDX_W'(idx_ff + 1'b1);
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff <= ST_CLEAR;
               clr_ff   <= '0;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ----- tb/tb_adaptive_frequency_model_core.sv -----
// Self-checking testbench for adaptive_frequency_model_core: directed and random encode and
// decode beats with an in-bench count table that predicts every response.
// Depends on afm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_adaptive_frequency_model_core;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   afm_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_strobe;
   afm_pkg::rsp_type rsp_item;

   // predicted model state
   logic [afm_pkg::COUNT_BITS-1:0] freq_count [afm_pkg::ALPHABET];
   logic [afm_pkg::COUNT_BITS-1:0] freq_total;

   afm_pkg::rsp_type pending_rsp [$];
   int unsigned      mismatch_count = 0;
   int unsigned      sent_count = 0;
   bit               quiet_stretch = 1'b0;

   adaptive_frequency_model_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_freq_table();
      for (int i = 0; i < afm_pkg::ALPHABET; i++) begin
         freq_count[i] = afm_pkg::COUNT_ONE;
      end
      freq_total = afm_pkg::TOTAL_RST;
   endfunction

   // Compute the response for one beat and apply its count update.
   function automatic afm_pkg::rsp_type code_symbol(afm_pkg::req_type r);
      afm_pkg::rsp_type               res;
      logic [afm_pkg::IDX_W-1:0]      sym;
      logic [afm_pkg::COUNT_BITS-1:0] low;
      logic [afm_pkg::COUNT_BITS-1:0] nxt;
      bit                             found;
      res = '0;
      low = '0;
      found = 1'b0;
      sym = r.symbol_in;
      res.total_count = 32'(freq_total);
      if (r.cmd == afm_pkg::CMD_ENCODE) begin
         if (sym >= afm_pkg::ALPHABET) sym = afm_pkg::EOS_SYM;
         for (int i = 0; i < sym; i++) low = low + freq_count[i];
      end else if (r.target_value >= freq_total) begin
         res.range_error = 1'b1;
         return res;
      end else begin
         sym = afm_pkg::EOS_SYM;
         for (int i = 0; i < afm_pkg::ALPHABET && !found; i++) begin
            nxt = low + freq_count[i];
            if (r.target_value < nxt) begin
               sym = afm_pkg::IDX_W'(i);
               found = 1'b1;
            end else begin
               low = nxt;
            end
         end
      end
      res.symbol_out = sym;
      res.low_bound = 32'(low);
      res.high_bound = 32'(low + freq_count[sym]);
      if (sym == afm_pkg::EOS_SYM) begin
         clear_freq_table();
      end else if (freq_total == afm_pkg::COUNT_MAX) begin
         res.overflow = 1'b1;
      end else begin
         freq_count[sym] = freq_count[sym] + 1'b1;
         freq_total = freq_total + 1'b1;
      end
      return res;
   endfunction

   function automatic afm_pkg::req_type make_req(logic cmd, logic [8:0] sym,
                                                 logic [31:0] tgt);
      afm_pkg::req_type r;
      r.cmd = cmd;
      r.symbol_in = sym;
      r.target_value = tgt;
      return r;
   endfunction

   function automatic logic [31:0] cum_below(int s);
      logic [afm_pkg::COUNT_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < s; i++) acc = acc + freq_count[i];
      return 32'(acc);
   endfunction

   // Target that falls somewhere inside symbol s's interval.
   function automatic logic [31:0] target_in(int s);
      return cum_below(s) + $urandom_range(0, 32'(freq_count[s]) - 1);
   endfunction

   function automatic int pick_data_symbol();
      case ($urandom_range(0, 3))
         0, 1:    return $urandom_range(0, 15);
         2:       return $urandom_range(0, 63);
         default: return $urandom_range(0, afm_pkg::ALPHABET - 2);
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 40) begin
         $display("%0t MISMATCH %s: got %h want %h", $realtime, field, got, want);
      end
      mismatch_count++;
   endtask

   // Send one beat: idle a random gap, raise start, hold until taken.
   task automatic send_item(afm_pkg::req_type item);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0) quiet_stretch = !quiet_stretch;
      gap = quiet_stretch ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(code_symbol(item));
      sent_count++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      afm_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat, symbol_out", 32'(rsp_item.symbol_out), '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.symbol_out !== want.symbol_out)
               report_mismatch("symbol_out", 32'(rsp_item.symbol_out), 32'(want.symbol_out));
            if (rsp_item.low_bound !== want.low_bound)
               report_mismatch("low_bound", rsp_item.low_bound, want.low_bound);
            if (rsp_item.high_bound !== want.high_bound)
               report_mismatch("high_bound", rsp_item.high_bound, want.high_bound);
            if (rsp_item.total_count !== want.total_count)
               report_mismatch("total_count", rsp_item.total_count, want.total_count);
            if (rsp_item.range_error !== want.range_error)
               report_mismatch("range_error", 32'(rsp_item.range_error), 32'(want.range_error));
            if (rsp_item.overflow !== want.overflow)
               report_mismatch("overflow", 32'(rsp_item.overflow), 32'(want.overflow));
         end
      end
   end

   task automatic test_boundary_items();
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd0, 32'd0));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd0, 32'hFFFF_FFFF));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd255, 32'd0));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd1, 32'h5555_5555));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'd0));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'h1FF, 32'd2));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'd3));
      // target equal to the total, then the largest target: both flagged
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'(freq_total)));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'hFFFF_FFFF));
      // last target below the total decodes end of stream
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'(freq_total) - 1));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'h0AA, 32'd255));
      // symbols past the alphabet saturate to end of stream
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'h1FF, 32'hAAAA_AAAA));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd257, 32'd0));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd256, 32'd0));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd128, 32'd0));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'd128));
      send_item(make_req(afm_pkg::CMD_DECODE, 9'd0, 32'd130));
      send_item(make_req(afm_pkg::CMD_ENCODE, 9'd256, 32'd0));
      drain_results();
   endtask

   // Streams of encode/decode beats, most closed by end of stream.
   task automatic test_random_streams(int unsigned stop_at);
      int unsigned len;
      int          s;
      logic [31:0] tgt;
      while (sent_count < stop_at) begin
         len = $urandom_range(1, 80);
         for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) < 6) begin
               send_item(make_req(afm_pkg::CMD_ENCODE, 9'(pick_data_symbol()), $urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0:          tgt = $urandom_range(32'(freq_total), 32'hFFFF_FFFF);
                  1, 2, 3, 4: tgt = $urandom_range(0, 32'(freq_total) - 1);
                  default: begin
                     s = pick_data_symbol();
                     tgt = target_in(s);
                  end
               endcase
               send_item(make_req(afm_pkg::CMD_DECODE, 9'($urandom_range(0, 511)), tgt));
            end
         end
         case ($urandom_range(0, 9))
            0, 1: ;  // leave the stream open, counts carry over
            2, 3: send_item(make_req(afm_pkg::CMD_ENCODE, 9'($urandom_range(257, 511)),
                                     $urandom));
            4, 5, 6: send_item(make_req(afm_pkg::CMD_ENCODE, 9'(afm_pkg::EOS_SYM), $urandom));
            default: send_item(make_req(afm_pkg::CMD_DECODE, 9'($urandom_range(0, 511)),
                                        target_in(afm_pkg::ALPHABET - 1)));
         endcase
         if ($urandom_range(0, 19) == 0) drain_results();
      end
      drain_results();
   endtask

   task automatic test_raw_items(int unsigned stop_at);
      logic [31:0] tgt;
      while (sent_count < stop_at) begin
         tgt = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'(freq_total) + 4);
         send_item(make_req(logic'($urandom_range(0, 1)), 9'($urandom_range(0, 511)), tgt));
      end
   endtask

   initial begin
      clear_freq_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_items();
      test_random_streams(sent_count + 1600);
      test_raw_items(sent_count + 400);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (afm_pkg::ALPHABET + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[adaptive_frequency_model_core] OK");
      end else begin
         $display("[adaptive_frequency_model_core] ERROR");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("[adaptive_frequency_model_core] ERROR");
      $finish;
   end

endmodule

// ----- adaptive_frequency_model_core.f -----
hw/rtl/afm_pkg.sv
hw/rtl/afm_count_ram.sv
hw/rtl/adaptive_frequency_model_core.sv
tb/tb_adaptive_frequency_model_core.sv
